/* rtl/gcd_lcm_unit_assert.svh */
// Assertion macros for the gcd_lcm_unit RTL.
// Used by modules that clock on i_clk with the active-low reset i_rst_n.
`ifndef GCD_LCM_UNIT_ASSERT_SVH
`define GCD_LCM_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GCDL_ASSERT_IMPL(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication.
`define GCDL_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* rtl/gcdl_pkg.sv */
// Shared types and constants for the gcd_lcm_unit block.
// No dependencies.
`default_nettype none

package gcdl_pkg;

    localparam int FIELD_W     = 32;
    localparam int LCM_W       = 64;
    localparam int IN_TDATA_W  = 2 * FIELD_W;
    localparam int OUT_TDATA_W = FIELD_W + LCM_W;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    // Top level to engine
    typedef struct packed {
        logic start;
        logic ack;
    } t_eng_ctl;

    // Engine to top level
    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_stat;

endpackage

`default_nettype wire

/* rtl/gcdl_alu.sv */
// Shared add/subtract unit with carry out.
// Depends on gcdl_pkg.
`default_nettype none

module gcdl_alu #(
    parameter int DW = 64
) (
    input  gcdl_pkg::t_alu_op i_op,
    input  logic [DW-1:0]     i_x,
    input  logic [DW-1:0]     i_y,
    output logic [DW-1:0]     o_res,
    output logic              o_carry    // for subtract: 1 when x >= y
);
    import gcdl_pkg::*;

    logic [DW-1:0] y_eff;
    logic          cin;
    logic [DW:0]   sum;

    always_comb begin
        case (i_op)
            ALU_SUB: begin
                y_eff = ~i_y;
                cin   = 1'b1;
            end
            default: begin
                y_eff = i_y;
                cin   = 1'b0;
            end
        endcase
        sum = {1'b0, i_x} + {1'b0, y_eff} + {{DW{1'b0}}, cin};
    end

    assign o_res   = sum[DW-1:0];
    assign o_carry = sum[DW];

endmodule

`default_nettype wire

/* rtl/gcdl_engine.sv */
// Sequencer for binary GCD, restoring division a/g and shift-add multiply.
// Depends on gcdl_pkg, gcdl_alu and gcd_lcm_unit_assert.svh.
`default_nettype none

`include "gcd_lcm_unit_assert.svh"

module gcdl_engine #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gcdl_pkg::t_eng_ctl         i_ctl,
    input  logic [OPERAND_WIDTH-1:0]   i_a,
    input  logic [OPERAND_WIDTH-1:0]   i_b,
    output gcdl_pkg::t_eng_stat        o_stat,
    output logic [OPERAND_WIDTH-1:0]   o_gcd,
    output logic [2*OPERAND_WIDTH-1:0] o_lcm
);
    import gcdl_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int DW = 2 * OPERAND_WIDTH;
    localparam int KW = $clog2(OPERAND_WIDTH);
    localparam int CW = $clog2(OPERAND_WIDTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_SHIFT,
        S_DIV,
        S_MUL,
        S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic [W-1:0]    r_u, n_u;
    logic [W-1:0]    r_v, n_v;
    logic [KW-1:0]   r_k, n_k;
    logic [W-1:0]    r_a, n_a;
    logic [W-1:0]    r_b, n_b;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [W:0]      r_rem, n_rem;
    logic [W-1:0]    r_q, n_q;
    logic [DW-1:0]   r_acc, n_acc;
    logic [DW-1:0]   r_mcand, n_mcand;

    t_alu_op         alu_op;
    logic [DW-1:0]   alu_x;
    logic [DW-1:0]   alu_y;
    logic [DW-1:0]   alu_res;
    logic            alu_carry;

    logic            u_gt_v;
    logic [W:0]      div_shift;

    gcdl_alu #(
        .DW (DW)
    ) u_alu (
        .i_op    (alu_op),
        .i_x     (alu_x),
        .i_y     (alu_y),
        .o_res   (alu_res),
        .o_carry (alu_carry)
    );

    assign u_gt_v    = (r_u > r_v);
    assign div_shift = {r_rem[W-1:0], r_q[W-1]};

    // Operand select for the shared unit
    always_comb begin
        alu_op = ALU_ADD;
        alu_x  = '0;
        alu_y  = '0;
        case (r_state)
            S_GCD: begin
                alu_op = ALU_SUB;
                alu_x  = u_gt_v ? DW'(r_u) : DW'(r_v);
                alu_y  = u_gt_v ? DW'(r_v) : DW'(r_u);
            end
            S_DIV: begin
                alu_op = ALU_SUB;
                alu_x  = DW'(div_shift);
                alu_y  = DW'(r_u);
            end
            S_MUL: begin
                alu_op = ALU_ADD;
                alu_x  = r_acc;
                alu_y  = r_mcand;
            end
            default: begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_u     = r_u;
        n_v     = r_v;
        n_k     = r_k;
        n_a     = r_a;
        n_b     = r_b;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_q     = r_q;
        n_acc   = r_acc;
        n_mcand = r_mcand;
        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_a = i_a;
                    n_b = i_b;
                    n_k = '0;
                    if (i_a == '0 || i_b == '0) begin
                        // one operand zero: gcd is the other, lcm is zero
                        n_u     = i_a | i_b;
                        n_acc   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_u     = i_a;
                        n_v     = i_b;
                        n_state = S_GCD;
                    end
                end
            end
            S_GCD: begin
                if (r_u == r_v) begin
                    n_state = S_SHIFT;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + KW'(1);
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (u_gt_v) begin
                    n_u = {1'b0, alu_res[W-1:1]};
                end else begin
                    n_v = {1'b0, alu_res[W-1:1]};
                end
            end
            S_SHIFT: begin
                // restore the common power of two
                if (r_k == '0) begin
                    n_q     = r_a;
                    n_rem   = '0;
                    n_cnt   = CW'(W);
                    n_state = S_DIV;
                end else begin
                    n_u = r_u << 1;
                    n_k = r_k - KW'(1);
                end
            end
            S_DIV: begin
                n_rem = alu_carry ? alu_res[W:0] : div_shift;
                n_q   = {r_q[W-2:0], alu_carry};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_mcand = DW'(r_b);
                    n_acc   = '0;
                    n_cnt   = CW'(W);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_q[0]) begin
                    n_acc = alu_res;
                end
                n_mcand = r_mcand << 1;
                n_q     = r_q >> 1;
                n_cnt   = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ctl.ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_u     <= n_u;
        r_v     <= n_v;
        r_k     <= n_k;
        r_a     <= n_a;
        r_b     <= n_b;
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_acc   <= n_acc;
        r_mcand <= n_mcand;
    end

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_gcd       = r_u;
    assign o_lcm       = r_acc;

    `GCDL_ASSERT_IMPL(a_gcd_nonzero, r_state == S_GCD, r_u != '0 && r_v != '0, "gcd operand zero")
    `GCDL_ASSERT_IMPL(a_rem_below_div, r_state == S_DIV, r_rem < {1'b0, r_u}, "remainder >= divisor")
    `GCDL_ASSERT_IMPL(a_start_idle, i_ctl.start, r_state == S_IDLE, "start while busy")

endmodule

`default_nettype wire

/* rtl/gcd_lcm_unit.sv */
// Top level of the GCD/LCM block: stream ports and result register.
// Depends on gcdl_pkg and gcdl_engine.
//
//  channel  dir  handshake           payload
//  s_axis   in   i_tvalid/o_tready   i_tdata: operand_a, operand_b
//  m_axis   out  o_tvalid/i_tready   o_tdata: gcd_value, lcm_value
//
// One transfer in at a time; the input is not ready while an item is in work.
// Zero operand: the engine goes from accept straight to its done state. Otherwise
// binary GCD steps and restoring the shared power of two run first, then restoring
// division and shift-add multiply over W bits each, then done (W = OPERAND_WIDTH).
// A result waits in the output register; a finished item holds until it frees.
// Reset is synchronous, active low, and clears only control state.
`default_nettype none

module gcd_lcm_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_tvalid,
    output logic                               o_tready,
    input  logic [gcdl_pkg::IN_TDATA_W-1:0]    i_tdata,   // operand_a, operand_b
    output logic                               o_tvalid,
    input  logic                               i_tready,
    output logic [gcdl_pkg::OUT_TDATA_W-1:0]   o_tdata    // gcd_value, lcm_value
);
    import gcdl_pkg::*;

    localparam int W = OPERAND_WIDTH;

    t_eng_ctl              eng_ctl;
    t_eng_stat             eng_stat;
    logic [W-1:0]          eng_gcd;
    logic [2*W-1:0]        eng_lcm;
    logic                  out_free;

    logic                  r_out_valid;
    logic [FIELD_W-1:0]    r_out_gcd;
    logic [LCM_W-1:0]      r_out_lcm;

    assign o_tready      = !eng_stat.busy;
    assign out_free      = !r_out_valid || i_tready;
    assign eng_ctl.start = i_tvalid && o_tready;
    assign eng_ctl.ack   = eng_stat.done && out_free;

    gcdl_engine #(
        .OPERAND_WIDTH (W)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (eng_ctl),
        .i_a     (i_tdata[W-1:0]),
        .i_b     (i_tdata[FIELD_W +: W]),
        .o_stat  (eng_stat),
        .o_gcd   (eng_gcd),
        .o_lcm   (eng_lcm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_ctl.ack) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
        if (eng_ctl.ack) begin
            r_out_gcd <= FIELD_W'(eng_gcd);
            r_out_lcm <= LCM_W'(eng_lcm);
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {r_out_lcm, r_out_gcd};

endmodule

`default_nettype wire
